### rtl/hld_pkg.sv
// hld_pkg: shared types and constants for the lowest-common-ancestor query block
// holds the beat structs, table entry layout, opcodes and walker states
// no dependencies
package hld_pkg;

  localparam int NODES       = 1024;
  localparam int NODE_W      = 10;
  localparam int DEPTH_W     = 11;
  localparam int TABLE_DEPTH = 1024;
  localparam int MOVE_W      = $clog2(NODES + 1);

  typedef logic [NODE_W-1:0]  node_t;
  typedef logic [DEPTH_W-1:0] depth_t;
  typedef logic [MOVE_W-1:0]  move_cnt_t;

  typedef enum logic {
    OP_WRITE = 1'b0,
    OP_QUERY = 1'b1
  } hld_op_t;

  typedef struct packed {
    hld_op_t opcode;
    node_t   node_a;
    node_t   node_b;
    node_t   parent_in;
    node_t   chain_head_in;
    depth_t  depth_in;
  } hld_in_t;

  typedef struct packed {
    node_t ancestor;
    logic  walk_overrun;
  } hld_out_t;

  typedef struct packed {
    node_t  parent;
    node_t  head;
    depth_t depth;
  } hld_entry_t;

  localparam int ENTRY_W = $bits(hld_entry_t);

  typedef struct packed {
    logic       we;
    node_t      waddr;
    hld_entry_t wdata;
    node_t      raddr0;
    node_t      raddr1;
  } hld_mem_req_t;

  typedef struct packed {
    logic     done;
    hld_out_t result;
  } hld_res_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_HEAD,
    ST_MOVE,
    ST_DONE
  } hld_state_t;

endpackage

### rtl/hld_table_ram.sv
// hld_table_ram: one write port, two read ports, registered read data
// generic storage for the node table; no package dependency
module hld_table_ram #(
  parameter int DEPTH = 1024,
  parameter int WIDTH = 31
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr0,
  input  logic [$clog2(DEPTH)-1:0] raddr1,
  output logic [WIDTH-1:0]         rdata0,
  output logic [WIDTH-1:0]         rdata1
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata0 <= mem[raddr0];
    rdata1 <= mem[raddr1];
  end

endmodule

### rtl/hld_walker.sv
// hld_walker: table writes and the chain-climbing sequencer for queries
// depends on hld_pkg; drives the node table ports of hld_table_ram
module hld_walker (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  hld_pkg::hld_in_t     in_data,
  output hld_pkg::hld_mem_req_t req,
  input  hld_pkg::hld_entry_t  rd0,
  input  hld_pkg::hld_entry_t  rd1,
  input  logic                 res_free,
  output hld_pkg::hld_res_t    res
);
  import hld_pkg::*;

  hld_state_t state, state_next;
  node_t      a, a_next;
  node_t      b, b_next;
  move_cnt_t  moves, moves_next;
  hld_out_t   result, result_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    a      <= a_next;
    b      <= b_next;
    moves  <= moves_next;
    result <= result_next;
  end

  always_comb begin
    state_next  = state;
    a_next      = a;
    b_next      = b;
    moves_next  = moves;
    result_next = result;
    req         = '0;
    req.raddr0  = a;
    req.raddr1  = b;
    res.done    = 1'b0;
    res.result  = result;
    in_ready    = 1'b0;
    unique case (state)
      ST_IDLE: begin
        in_ready = !rst;
        if (in_valid && !rst) begin
          if (in_data.opcode == OP_WRITE) begin
            req.we           = 1'b1;
            req.waddr        = in_data.node_a;
            req.wdata.parent = in_data.parent_in;
            req.wdata.head   = in_data.chain_head_in;
            req.wdata.depth  = in_data.depth_in;
          end else begin
            a_next     = in_data.node_a;
            b_next     = in_data.node_b;
            moves_next = '0;
            req.raddr0 = in_data.node_a;
            req.raddr1 = in_data.node_b;
            state_next = ST_HEAD;
          end
        end
      end
      ST_HEAD: begin
        if (rd0.head == rd1.head) begin
          result_next.ancestor     = (rd0.depth > rd1.depth) ? b : a;
          result_next.walk_overrun = 1'b0;
          state_next               = ST_DONE;
        end else if (moves >= move_cnt_t'(NODES)) begin
          result_next.ancestor     = '0;
          result_next.walk_overrun = 1'b1;
          state_next               = ST_DONE;
        end else begin
          req.raddr0 = rd0.head;
          req.raddr1 = rd1.head;
          state_next = ST_MOVE;
        end
      end
      ST_MOVE: begin
        // rd0/rd1 now hold the entries of the two chain heads
        if (rd1.depth < rd0.depth) begin
          a_next = rd0.parent;
        end else begin
          b_next = rd1.parent;
        end
        moves_next = move_cnt_t'(moves + 1'b1);
        req.raddr0 = a_next;
        req.raddr1 = b_next;
        state_next = ST_HEAD;
      end
      ST_DONE: begin
        if (res_free) begin
          res.done   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

### rtl/hld_lca_query.sv
// hld_lca_query: top level of the lowest-common-ancestor query block
// depends on hld_pkg, hld_table_ram and hld_walker
//
// Input channel (in_valid/in_ready/in_data) carries two kinds of beat. A write
// beat stores parent, chain head and depth of node_a in the node table; it
// gives no result. A query beat names node_a and node_b; the block climbs
// chain by chain until both nodes share a chain head and returns the
// shallower node on the output channel (out_valid/out_ready/out_data), or
// walk_overrun with ancestor 0 after NODES chain moves. A query holds the
// input until its result is passed to the output register. Each chain move is
// two dependent reads of the node table: the entries of the two current nodes
// give their chain heads, the entries of the heads give depth and parent. The
// table has one write and two read ports with registered read data.
// The result sits in an output register; while the receiver stalls the block
// keeps taking write beats and starts the next query, which waits in its last
// state until the register frees up.
// Reset clears control state only; table entries are undefined until written.
module hld_lca_query (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  hld_pkg::hld_in_t in_data,
  output logic             out_valid,
  input  logic             out_ready,
  output hld_pkg::hld_out_t out_data
);
  import hld_pkg::*;

  hld_mem_req_t req;
  hld_entry_t   rd0;
  hld_entry_t   rd1;
  hld_res_t     res;
  logic         res_free;

  assign res_free = !out_valid || out_ready;

  hld_table_ram #(
    .DEPTH(TABLE_DEPTH),
    .WIDTH(ENTRY_W)
  ) u_table (
    .clk   (clk),
    .we    (req.we),
    .waddr (req.waddr),
    .wdata (req.wdata),
    .raddr0(req.raddr0),
    .raddr1(req.raddr1),
    .rdata0(rd0),
    .rdata1(rd1)
  );

  hld_walker u_walker (
    .clk     (clk),
    .rst     (rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_data (in_data),
    .req     (req),
    .rd0     (rd0),
    .rd1     (rd1),
    .res_free(res_free),
    .res     (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res.done) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res.done) begin
      out_data <= res.result;
    end
  end

endmodule

### rtl/hld_lca_checker.sv
// hld_lca_checker: port-level assertions for hld_lca_query
// depends on hld_pkg; attached to the top level by the bind below
module hld_lca_checker (
  input logic              clk,
  input logic              rst,
  input logic              in_valid,
  input logic              in_ready,
  input hld_pkg::hld_in_t  in_data,
  input logic              out_valid,
  input logic              out_ready,
  input hld_pkg::hld_out_t out_data
);
  import hld_pkg::*;

  // a query beat occupies the walker for at least the next cycle
  a_query_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && in_data.opcode == OP_QUERY |=> !in_ready)
    else $error("input ready right after a query beat");

  // a write beat never blocks the input
  a_write_free: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && in_data.opcode == OP_WRITE |=> in_ready)
    else $error("input blocked after a write beat");

  // overrun results carry ancestor zero
  a_overrun_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.walk_overrun |-> out_data.ancestor == '0)
    else $error("overrun result with nonzero ancestor");

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("stalled result changed");

endmodule

bind hld_lca_query hld_lca_checker u_chk (.*);

### tb/tb_top.sv
`timescale 1ns / 1ps
// tb_top: self-checking testbench for the hld_lca_query common-ancestor block
// writes chain tables, sends queries, and checks each result against a local tree walk
// depends on hld_pkg and the hld_lca_query rtl
module tb_top;
  import hld_pkg::*;

  localparam int STALL_LIMIT = 20000;
  localparam int MAX_TREE    = 160;
  localparam int MAX_REPORTS = 10;

  logic     clk;
  logic     rst = 1'b1;
  logic     in_valid = 1'b0;
  logic     in_ready;
  hld_in_t  in_data = '0;
  logic     out_valid;
  logic     out_ready = 1'b0;
  hld_out_t out_data;

  // local copy of the node tables
  node_t  anc_parent [TABLE_DEPTH];
  node_t  anc_head   [TABLE_DEPTH];
  depth_t anc_depth  [TABLE_DEPTH];
  bit     anc_known  [TABLE_DEPTH];
  node_t  known_nodes[$];
  node_t  tree_nodes[$];

  hld_out_t expected_ancestors[$];
  int       mismatches = 0;
  int       items_sent = 0;
  int       send_idle_pct = 0;
  int       recv_idle_pct = 0;
  int       stall_cycles = 0;

  hld_lca_query u_top (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // climbs both nodes chain by chain; returns 0 if any unwritten entry would be read
  function automatic bit walk_lca(input node_t a_in, input node_t b_in, output hld_out_t res);
    node_t a;
    node_t b;
    node_t ha;
    node_t hb;
    int    moves;
    a = a_in;
    b = b_in;
    moves = 0;
    res = '0;
    while (1) begin
      if (!(anc_known[a] && anc_known[b] && anc_known[anc_head[a]] && anc_known[anc_head[b]]))
        return 1'b0;
      if (anc_head[a] == anc_head[b]) begin
        res.ancestor = (anc_depth[a] > anc_depth[b]) ? b : a;
        return 1'b1;
      end
      if (moves >= NODES) begin
        res.walk_overrun = 1'b1;
        return 1'b1;
      end
      ha = anc_head[a];
      hb = anc_head[b];
      if (anc_depth[hb] < anc_depth[ha]) a = anc_parent[ha];
      else b = anc_parent[hb];
      moves++;
    end
    return 1'b0;
  endfunction

  task automatic send_beat(input hld_in_t item);
    hld_out_t res;
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= item;
    do @(posedge clk); while (!in_ready);
    items_sent++;
    if (item.opcode == OP_WRITE) begin
      if (!anc_known[item.node_a]) known_nodes.insert(known_nodes.size(), item.node_a);
      anc_parent[item.node_a] = item.parent_in;
      anc_head[item.node_a]   = item.chain_head_in;
      anc_depth[item.node_a]  = item.depth_in;
      anc_known[item.node_a]  = 1'b1;
    end else begin
      void'(walk_lca(item.node_a, item.node_b, res));
      expected_ancestors.insert(expected_ancestors.size(), res);
    end
  endtask

  task automatic write_node(input node_t n, input node_t par, input node_t head, input depth_t d);
    hld_in_t item;
    item.opcode        = OP_WRITE;
    item.node_a        = n;
    item.node_b        = node_t'($urandom());
    item.parent_in     = par;
    item.chain_head_in = head;
    item.depth_in      = d;
    send_beat(item);
  endtask

  task automatic query_pair(input node_t a, input node_t b);
    hld_in_t item;
    item.opcode        = OP_QUERY;
    item.node_a        = a;
    item.node_b        = b;
    item.parent_in     = node_t'($urandom());
    item.chain_head_in = node_t'($urandom());
    item.depth_in      = depth_t'($urandom_range(0, 1024));
    send_beat(item);
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    do @(posedge clk); while (expected_ancestors.size() != 0);
  endtask

  // random tree, decomposed into heavy chains, written parents first
  task automatic build_tree();
    int    n;
    int    cut;
    int    i;
    int    par_idx  [MAX_TREE];
    int    sub_sz   [MAX_TREE];
    int    heavy    [MAX_TREE];
    int    head_idx [MAX_TREE];
    int    lvl      [MAX_TREE];
    bit    taken    [TABLE_DEPTH];
    node_t pick;
    n = ($urandom_range(0, 9) == 0) ? $urandom_range(41, MAX_TREE) : $urandom_range(1, 40);
    tree_nodes.delete();
    for (i = 0; i < n; i++) begin
      do pick = node_t'($urandom_range(0, TABLE_DEPTH - 1)); while (taken[pick]);
      taken[pick] = 1'b1;
      tree_nodes.insert(tree_nodes.size(), pick);
      if (i == 0) par_idx[i] = 0;
      else if ($urandom_range(0, 1) == 0) par_idx[i] = i - 1;
      else par_idx[i] = $urandom_range(0, i - 1);
      sub_sz[i] = 1;
      heavy[i]  = -1;
    end
    for (i = n - 1; i > 0; i--) sub_sz[par_idx[i]] += sub_sz[i];
    for (i = 1; i < n; i++)
      if (heavy[par_idx[i]] < 0 || sub_sz[i] > sub_sz[heavy[par_idx[i]]]) heavy[par_idx[i]] = i;
    head_idx[0] = 0;
    lvl[0]      = 1;
    for (i = 1; i < n; i++) begin
      head_idx[i] = (heavy[par_idx[i]] == i) ? head_idx[par_idx[i]] : i;
      lvl[i]      = lvl[par_idx[i]] + 1;
    end
    // partly written tree now and then
    cut = ($urandom_range(0, 9) == 0) ? $urandom_range(1, n) : n;
    for (i = 0; i < cut; i++)
      write_node(tree_nodes[i], tree_nodes[par_idx[i]], tree_nodes[head_idx[i]],
                 depth_t'(lvl[i]));
  endtask

  task automatic test_table_extremes();
    write_node(node_t'(0), node_t'(0), node_t'(0), depth_t'(1));
    write_node(node_t'(1023), node_t'(1023), node_t'(1023), depth_t'(1024));
    query_pair(node_t'(0), node_t'(0));
    query_pair(node_t'(1023), node_t'(1023));
  endtask

  task automatic test_walk_overrun();
    query_pair(node_t'(1023), node_t'(0));
    query_pair(node_t'(0), node_t'(1023));
  endtask

  task automatic test_small_tree();
    write_node(node_t'(5), node_t'(0), node_t'(0), depth_t'(2));
    write_node(node_t'(6), node_t'(5), node_t'(0), depth_t'(3));
    write_node(node_t'(7), node_t'(0), node_t'(7), depth_t'(2));
    write_node(node_t'(8), node_t'(7), node_t'(7), depth_t'(3));
    query_pair(node_t'(6), node_t'(8));
    query_pair(node_t'(8), node_t'(6));
    query_pair(node_t'(6), node_t'(5));
    query_pair(node_t'(5), node_t'(6));
    query_pair(node_t'(8), node_t'(7));
  endtask

  task automatic test_equal_depth();
    write_node(node_t'(9), node_t'(0), node_t'(0), depth_t'(2));
    query_pair(node_t'(5), node_t'(9));
    query_pair(node_t'(9), node_t'(5));
    drain_results();
  endtask

  task automatic test_random_walks(input int send_pct, input int recv_pct, input int n_items);
    int       stop_at;
    int       nq;
    int       r;
    node_t    a;
    node_t    b;
    hld_out_t res;
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
    stop_at = items_sent + n_items;
    while (items_sent < stop_at) begin
      build_tree();
      nq = $urandom_range(4, 20);
      repeat (nq) begin
        r = $urandom_range(0, 99);
        if (r < 8) begin
          write_node(node_t'($urandom()), node_t'($urandom()), node_t'($urandom()),
                     depth_t'($urandom_range(0, 1024)));
        end else begin
          if (r < 18) begin
            a = known_nodes[$urandom_range(0, known_nodes.size() - 1)];
            b = known_nodes[$urandom_range(0, known_nodes.size() - 1)];
          end else begin
            a = tree_nodes[$urandom_range(0, tree_nodes.size() - 1)];
            b = tree_nodes[$urandom_range(0, tree_nodes.size() - 1)];
          end
          if (walk_lca(a, b, res)) query_pair(a, b);
        end
      end
      if ($urandom_range(0, 9) == 0) drain_results();
    end
    drain_results();
  endtask

  always @(posedge clk) begin
    if (rst) out_ready <= 1'b0;
    else out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
  end

  always @(posedge clk) begin
    hld_out_t exp_res;
    if (!rst && out_valid && out_ready) begin
      if (expected_ancestors.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("unexpected result: ancestor %0d overrun %0b",
                   out_data.ancestor, out_data.walk_overrun);
      end else begin
        exp_res = expected_ancestors.pop_front();
        if (out_data.ancestor !== exp_res.ancestor
            || out_data.walk_overrun !== exp_res.walk_overrun) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS)
            $display("mismatch: expected ancestor %0d overrun %0b, got ancestor %0d overrun %0b",
                     exp_res.ancestor, exp_res.walk_overrun,
                     out_data.ancestor, out_data.walk_overrun);
        end
      end
    end
  end

  // no progress while work is pending ends the run
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)
        || (!in_valid && expected_ancestors.size() == 0)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    send_idle_pct = 9;
    recv_idle_pct = 69;
    test_table_extremes();
    test_walk_overrun();
    test_small_tree();
    test_equal_depth();
    test_random_walks(9, 69, 240);
    test_random_walks(69, 9, 230);
    test_random_walks(0, 0, 230);
    repeat (60) @(posedge clk);
    if (mismatches == 0 && expected_ancestors.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
